// File: src/rrts_pkg.sv
// Shared types and constants for the round-robin tick scheduler.
`default_nettype none

package rrts_pkg;

	typedef enum logic [1:0] {
		ST_DEAD     = 2'd0,
		ST_RUNNABLE = 2'd1,
		ST_RUNNING  = 2'd2,
		ST_BLOCKED  = 2'd3
	} slot_state_t;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_SLEEP = 2'd1,
		OP_EXIT  = 2'd2,
		OP_FORK  = 2'd3
	} op_t;

	typedef struct packed {
		slot_state_t state;
		logic [15:0] sleep;
		logic [7:0]  slice;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam logic [7:0] SLICE_LIMIT_RST = 8'd10;
	localparam logic [7:0] SLICE_FIRST     = 8'd1;

	localparam entry_t RST_ENTRY      = '{state: ST_DEAD,    sleep: 16'd0, slice: 8'd0};
	localparam entry_t RST_IDLE_ENTRY = '{state: ST_RUNNING, sleep: 16'd0, slice: 8'd0};

	typedef struct packed {
		logic accept;
		logic cur_load;
		logic issue;
		logic walk_proc;
		logic fork_proc;
		logic fin;
		logic pick_wr;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic in_nop;
		logic op_fork;
		logic s1_vld;
		logic s1_last;
		logic s1_dead;
		logic fin_move;
		logic rsp_free;
	} dp_status_t;

endpackage

`default_nettype wire

// File: src/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rrts_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/rrts_ctrl.sv
// Sequencing state machine for the scheduler.
`default_nettype none

module rrts_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire rrts_pkg::dp_status_t status,
	output rrts_pkg::dp_cmd_t        cmd
);

	import rrts_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CUR   = 7'b0000010,
		S_WALK  = 7'b0000100,
		S_FSCAN = 7'b0001000,
		S_FIN   = 7'b0010000,
		S_PRD   = 7'b0100000,
		S_DONE  = 7'b1000000
	} fsm_t;

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.in_nop ? S_DONE : S_CUR;
				end
			end
			S_CUR: begin
				cmd.cur_load = 1'b1;
				state_d      = status.op_fork ? S_FSCAN : S_WALK;
			end
			S_WALK: begin
				cmd.issue     = 1'b1;
				cmd.walk_proc = 1'b1;
				if (status.s1_vld && status.s1_last) begin
					state_d = S_FIN;
				end
			end
			S_FSCAN: begin
				cmd.issue     = 1'b1;
				cmd.fork_proc = 1'b1;
				if (status.s1_vld && (status.s1_dead || status.s1_last)) begin
					state_d = S_DONE;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = status.fin_move ? S_PRD : S_DONE;
			end
			S_PRD: begin
				cmd.pick_wr = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (status.rsp_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/rrts_datapath.sv
// Slot table, walk counters, selection logic and result register.
`default_nettype none

module rrts_datapath #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [1:0]          operation,
	input  wire logic [15:0]         sleep_ticks,
	input  wire logic                cfg_valid,
	input  wire logic [7:0]          slice_limit,
	input  wire rrts_pkg::dp_cmd_t   cmd,
	output rrts_pkg::dp_status_t     status,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output logic [3:0]               running_slot,
	output logic                     fork_ok,
	output logic [3:0]               fork_slot
);

	import rrts_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	// control state
	logic [7:0]           slice_limit_q;
	logic [IW-1:0]        running_q;
	logic [NUM_SLOTS-1:0] valid_q;
	logic [CW-1:0]        iss_left_q;
	logic                 rd_vld_s1;
	logic                 found_q;
	logic                 rsp_valid_q;

	// payload
	op_t           op_q;
	logic [15:0]   ticks_q;
	entry_t        cur_q;
	logic [IW-1:0] iss_idx_q;
	logic [IW-1:0] rd_idx_s1;
	logic          rd_last_s1;
	logic          rd_hit_s1;
	logic [IW-1:0] cand_q;
	logic          fork_ok_q;
	logic [IW-1:0] fork_slot_q;
	logic [3:0]    rsp_slot_q;
	logic          rsp_fork_ok_q;
	logic [3:0]    rsp_fork_slot_q;

	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	entry_t             ram_wentry;
	logic               ram_re;
	logic [IW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	entry_t        rd_entry;
	entry_t        walk_e;
	entry_t        cur_mod;
	entry_t        demoted;
	logic          cur_cont;
	logic [IW-1:0] pick;
	logic          fin_move;
	logic          issue_now;
	logic          walk_hit;
	logic          fork_hit;

	rrts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// unwritten slots read as their reset contents
	always_comb begin
		if (rd_hit_s1) begin
			rd_entry = entry_t'(ram_rdata);
		end else if (rd_idx_s1 == '0) begin
			rd_entry = RST_IDLE_ENTRY;
		end else begin
			rd_entry = RST_ENTRY;
		end
	end

	always_comb begin
		walk_e = rd_entry;
		if (rd_entry.state == ST_BLOCKED && rd_entry.sleep != 16'd0) begin
			walk_e.sleep = rd_entry.sleep - 16'd1;
			if (rd_entry.sleep == 16'd1) begin
				walk_e.state = ST_RUNNABLE;
			end
		end
	end

	always_comb begin
		cur_mod = rd_entry;
		case (op_q)
			OP_SLEEP: begin
				cur_mod.state = ST_BLOCKED;
				cur_mod.sleep = ticks_q;
			end
			OP_EXIT: begin
				cur_mod.state = ST_DEAD;
			end
			default: begin
				cur_mod = rd_entry;
			end
		endcase
	end

	always_comb begin
		cur_cont = (cur_q.state == ST_RUNNING) && (cur_q.slice != slice_limit_q);
		demoted  = cur_q;
		if (cur_q.state == ST_RUNNING) begin
			demoted.state = ST_RUNNABLE;
			demoted.slice = 8'd0;
		end
		if (found_q) begin
			pick = cand_q;
		end else if (demoted.state == ST_RUNNABLE) begin
			pick = running_q;
		end else begin
			pick = '0;
		end
		fin_move = !cur_cont && (pick != running_q);
	end

	assign issue_now = cmd.issue && (iss_left_q != '0);
	assign walk_hit  = cmd.walk_proc && rd_vld_s1 && !found_q && (rd_idx_s1 != '0) &&
	                   (walk_e.state == ST_RUNNABLE);
	assign fork_hit  = cmd.fork_proc && rd_vld_s1 && (rd_entry.state == ST_DEAD);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = running_q;
		if (cmd.accept) begin
			ram_re = 1'b1;
		end else if (issue_now) begin
			ram_re    = 1'b1;
			ram_raddr = iss_idx_q;
		end else if (cmd.fin && fin_move) begin
			ram_re    = 1'b1;
			ram_raddr = pick;
		end
	end

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = rd_idx_s1;
		ram_wentry = walk_e;
		if (cmd.walk_proc && rd_vld_s1) begin
			ram_we = 1'b1;
		end else if (fork_hit) begin
			ram_we     = 1'b1;
			ram_wentry = '{state: ST_RUNNABLE, sleep: cur_q.sleep, slice: cur_q.slice};
		end else if (cmd.fin) begin
			ram_we    = 1'b1;
			ram_waddr = running_q;
			if (cur_cont) begin
				ram_wentry = '{state: ST_RUNNING, sleep: cur_q.sleep,
				               slice: cur_q.slice + 8'd1};
			end else if (pick == running_q) begin
				ram_wentry = '{state: ST_RUNNING, sleep: demoted.sleep, slice: SLICE_FIRST};
			end else begin
				ram_wentry = demoted;
			end
		end else if (cmd.pick_wr) begin
			ram_we     = 1'b1;
			ram_wentry = '{state: ST_RUNNING, sleep: rd_entry.sleep, slice: SLICE_FIRST};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_limit_q <= SLICE_LIMIT_RST;
			running_q     <= '0;
			valid_q       <= '0;
			iss_left_q    <= '0;
			rd_vld_s1     <= 1'b0;
			found_q       <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				slice_limit_q <= slice_limit;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			rd_vld_s1 <= ram_re;
			if (cmd.cur_load) begin
				iss_left_q <= status.op_fork ? CW'(NUM_SLOTS) : CW'(NUM_SLOTS - 1);
				found_q    <= 1'b0;
			end else begin
				if (issue_now) begin
					iss_left_q <= iss_left_q - 1'b1;
				end
				if (walk_hit) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.fin && !cur_cont) begin
				running_q <= pick;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1  <= ram_raddr;
		rd_hit_s1  <= valid_q[ram_raddr];
		rd_last_s1 <= issue_now && (iss_left_q == CW'(1));
		if (cmd.accept) begin
			op_q        <= op_t'(operation);
			ticks_q     <= sleep_ticks;
			fork_ok_q   <= 1'b0;
			fork_slot_q <= '0;
		end
		if (cmd.cur_load) begin
			cur_q     <= cur_mod;
			iss_idx_q <= status.op_fork ? '0 : wrap_inc(running_q);
		end else if (issue_now) begin
			iss_idx_q <= wrap_inc(iss_idx_q);
		end
		if (walk_hit) begin
			cand_q <= rd_idx_s1;
		end
		if (fork_hit) begin
			fork_ok_q   <= 1'b1;
			fork_slot_q <= rd_idx_s1;
		end
		if (cmd.out_load) begin
			rsp_slot_q      <= 4'(running_q);
			rsp_fork_ok_q   <= fork_ok_q;
			rsp_fork_slot_q <= 4'(fork_slot_q);
		end
	end

	always_comb begin
		status.in_nop   = (op_t'(operation) == OP_SLEEP) && (sleep_ticks == 16'd0);
		status.op_fork  = (op_q == OP_FORK);
		status.s1_vld   = rd_vld_s1;
		status.s1_last  = rd_last_s1;
		status.s1_dead  = (rd_entry.state == ST_DEAD);
		status.fin_move = fin_move;
		status.rsp_free = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid    = rsp_valid_q;
	assign running_slot = rsp_slot_q;
	assign fork_ok      = rsp_fork_ok_q;
	assign fork_slot    = rsp_fork_slot_q;

endmodule

`default_nettype wire

// File: src/round_robin_tick_scheduler.sv
// Top level of the round-robin tick scheduler: controller, datapath and port wiring.
//
//  channel | signals                              | direction | carries
//  --------+--------------------------------------+-----------+------------------------------
//  req     | req_valid req_ready                  | in        | operation, sleep_ticks
//  rsp     | rsp_valid rsp_ready                  | out       | running_slot, fork_ok, fork_slot
//  cfg     | cfg_valid cfg_ready                  | in        | slice_limit
//
// A tick, sleep or exit item reads the running slot and walks the table, one slot table read a cycle
// through the single read port of the slot RAM while the other slots are counted down, then
// settles the running slot and, if a new slot is chosen, promotes it.
// A fork item searches upward for the lowest dead slot instead of walking; a sleep of zero
// ticks skips the walk. Reset needs no clearing pass: per-slot valid bits make unwritten slots
// read as dead (slot 0 as running). A result waiting in the output register does not stop
// the next item from being taken; only its completion waits for the register to drain.
`default_nettype none

module round_robin_tick_scheduler #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] sleep_ticks,
	// result channel
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [3:0]       running_slot,
	output logic             fork_ok,
	output logic [3:0]       fork_slot,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  slice_limit
);

	import rrts_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// the user must write the limit register only while idle; the block does not enforce it, so take every write at once
	assign cfg_ready = 1'b1;

	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rrts_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (operation),
		.sleep_ticks  (sleep_ticks),
		.cfg_valid    (cfg_valid),
		.slice_limit  (slice_limit),
		.cmd          (cmd),
		.status       (status),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.running_slot (running_slot),
		.fork_ok      (fork_ok),
		.fork_slot    (fork_slot)
	);

endmodule

`default_nettype wire

// File: tb/round_robin_tick_scheduler_test.sv
// Self-checking testbench for the round-robin tick scheduler: directed and random item traffic.
module round_robin_tick_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rrts_pkg::*;

	localparam int SLOTS         = 16;
	// A tick walks every slot once, then settles and promotes.
	localparam int SETTLE_CYCLES = SLOTS + 10;
	localparam int CYCLE_LIMIT   = 500000;

	typedef struct packed {
		logic [3:0] running_slot;
		logic       fork_ok;
		logic [3:0] fork_slot;
	} sched_outcome_t;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// Block inputs, all known from time zero
	logic        req_valid   = 1'b0;
	logic [1:0]  operation   = OP_TICK;
	logic [15:0] sleep_ticks = 16'd0;
	logic        rsp_ready   = 1'b0;
	logic        cfg_valid   = 1'b0;
	logic [7:0]  slice_limit = SLICE_LIMIT_RST;

	// Block outputs
	logic       req_ready;
	logic       rsp_valid;
	logic [3:0] running_slot;
	logic       fork_ok;
	logic [3:0] fork_slot;
	logic       cfg_ready;

	round_robin_tick_scheduler #(
		.NUM_SLOTS(SLOTS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.operation   (operation),
		.sleep_ticks (sleep_ticks),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.running_slot(running_slot),
		.fork_ok     (fork_ok),
		.fork_slot   (fork_slot),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.slice_limit (slice_limit)
	);

	// Scheduler image kept alongside the block
	slot_state_t    proc_state [SLOTS];
	logic [15:0]    proc_sleep [SLOTS];
	logic [7:0]     proc_slice [SLOTS];
	logic [3:0]     current_slot;
	logic [7:0]     limit_image;

	// Outcomes still owed by the block, oldest first
	sched_outcome_t owed_outcomes [$];

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	// Receiver stall pattern
	int unsigned ready_hold = 0;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Count down sleepers, then either lengthen the running slice or rotate.
	function automatic void rotate_on_tick();
		logic [3:0] cur;
		logic [3:0] idx;
		logic [3:0] pick;
		bit         found;
		cur = current_slot;
		// Count down every blocked sleeper other than the running slot.
		for (int k = 1; k < SLOTS; k++) begin
			idx = cur + 4'(k);
			if (proc_state[idx] == ST_BLOCKED && proc_sleep[idx] != 16'd0) begin
				proc_sleep[idx] = proc_sleep[idx] - 16'd1;
				if (proc_sleep[idx] == 16'd0)
					proc_state[idx] = ST_RUNNABLE;
			end
		end
		// Still within its slice: extend, wrapping past 255 if need be.
		if (proc_state[cur] == ST_RUNNING && proc_slice[cur] != limit_image) begin
			proc_slice[cur] = proc_slice[cur] + 8'd1;
			return;
		end
		if (proc_state[cur] == ST_RUNNING) begin
			proc_state[cur] = ST_RUNNABLE;
			proc_slice[cur] = 8'd0;
		end
		// Next runnable slot after the running one, never the idle slot here.
		pick  = cur;
		found = 1'b0;
		for (int k = 1; k < SLOTS && !found; k++) begin
			idx = cur + 4'(k);
			if (idx != 4'd0 && proc_state[idx] == ST_RUNNABLE) begin
				pick  = idx;
				found = 1'b1;
			end
		end
		// Else keep the demoted slot if runnable, or fall back to the idle slot, whatever its state.
		if (proc_state[pick] != ST_RUNNABLE)
			pick = 4'd0;
		current_slot     = pick;
		proc_state[pick] = ST_RUNNING;
		proc_slice[pick] = SLICE_FIRST;
	endfunction

	// Apply one item to the image and queue the outcome it should produce.
	function automatic void schedule_item(input op_t op, input logic [15:0] ticks);
		sched_outcome_t outcome;
		logic [3:0]     cur;
		bit             found;
		cur     = current_slot;
		outcome = '0;
		found   = 1'b0;
		case (op)
			OP_TICK: begin
				rotate_on_tick();
			end
			OP_SLEEP: begin
				// A sleep of zero ticks leaves everything as it is.
				if (ticks != 16'd0) begin
					proc_state[cur] = ST_BLOCKED;
					proc_sleep[cur] = ticks;
					rotate_on_tick();
				end
			end
			OP_EXIT: begin
				proc_state[cur] = ST_DEAD;
				rotate_on_tick();
			end
			default: begin
				// Fork: claim the lowest dead slot, no tick.
				for (int s = 0; s < SLOTS && !found; s++) begin
					if (proc_state[s] == ST_DEAD) begin
						found             = 1'b1;
						proc_state[s]     = ST_RUNNABLE;
						proc_slice[s]     = proc_slice[cur];
						proc_sleep[s]     = proc_sleep[cur];
						outcome.fork_ok   = 1'b1;
						outcome.fork_slot = 4'(s);
					end
				end
			end
		endcase
		outcome.running_slot = current_slot;
		owed_outcomes.push_back(outcome);
	endfunction

	function automatic void reset_image();
		for (int s = 0; s < SLOTS; s++) begin
			proc_state[s] = ST_DEAD;
			proc_sleep[s] = 16'd0;
			proc_slice[s] = 8'd0;
		end
		proc_state[0] = ST_RUNNING;
		current_slot  = 4'd0;
		limit_image   = SLICE_LIMIT_RST;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		sched_outcome_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (owed_outcomes.size() == 0) begin
				$error("unexpected result: running_slot %0d fork_ok %0d fork_slot %0d",
					running_slot, fork_ok, fork_slot);
				error_count++;
			end else begin
				want = owed_outcomes.pop_front();
				if (running_slot !== want.running_slot) begin
					$error("running_slot: expected %0d, got %0d", want.running_slot,
						running_slot);
					error_count++;
				end
				if (fork_ok !== want.fork_ok) begin
					$error("fork_ok: expected %0d, got %0d", want.fork_ok, fork_ok);
					error_count++;
				end
				if (fork_slot !== want.fork_slot) begin
					$error("fork_slot: expected %0d, got %0d", want.fork_slot, fork_slot);
					error_count++;
				end
			end
		end
	end

	// Cycle counter and run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: the stall pattern changes character as bits 9:8 of the cycle count advance.
	always @(negedge clk) begin
		logic level;
		level = rsp_ready;
		if (ready_hold == 0) begin
			case (cycle_count[9:8])
				2'd0: begin
					// stretch with no stalls at all
					level      = 1'b1;
					ready_hold = 1;
				end
				2'd1: begin
					level      = 1'($urandom_range(0, 1));
					ready_hold = $urandom_range(1, 3);
				end
				2'd2: begin
					// long stalls broken by short ready windows
					level      = ~rsp_ready;
					ready_hold = level ? $urandom_range(1, 4) : $urandom_range(1, 16);
				end
				default: begin
					level      = 1'($urandom_range(0, 1));
					ready_hold = $urandom_range(1, 8);
				end
			endcase
		end
		ready_hold--;
		rsp_ready <= level;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one item and hold it until accepted.
	task automatic send_request(input op_t op, input logic [15:0] ticks);
		@(negedge clk);
		req_valid   <= 1'b1;
		operation   <= op;
		sleep_ticks <= ticks;
		do
			@(posedge clk);
		while (!req_ready);
		schedule_item(op, ticks);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		@(negedge clk);
		req_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Drop valid and wait for every owed outcome to come back.
	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (owed_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Write the slice limit only once the block has gone quiet.
	task automatic write_slice_limit(input logic [7:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid   <= 1'b1;
		slice_limit <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		limit_image = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic op_t pick_operation(input int unsigned tick_weight);
		int unsigned roll;
		int unsigned rest;
		roll = $urandom_range(0, 99);
		rest = 100 - tick_weight;
		if (roll < tick_weight)
			return OP_TICK;
		if (roll < tick_weight + rest * 35 / 100)
			return OP_SLEEP;
		if (roll < tick_weight + rest * 65 / 100)
			return OP_EXIT;
		return OP_FORK;
	endfunction

	// Mostly short sleeps so sleepers wake, with zero and full-range values mixed in.
	function automatic logic [15:0] pick_sleep_ticks();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 16'($urandom_range(1, 8));
		if (roll < 75)
			return 16'd0;
		if (roll < 90)
			return 16'($urandom_range(9, 300));
		return 16'($urandom_range(0, 65535));
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Exit and sleep the idle slot with nothing runnable: slot 0 is taken back.
	task automatic test_idle_fallback();
		send_request(OP_EXIT, 16'd0);
		send_request(OP_SLEEP, 16'd1);
	endtask

	// A sleep of zero ticks must not tick.
	task automatic test_zero_sleep();
		send_request(OP_SLEEP, 16'd0);
		send_request(OP_TICK, 16'hFFFF);
	endtask

	// Fill every free slot, then one fork more that must fail.
	task automatic test_fork_table_full();
		for (int n = 0; n < SLOTS; n++)
			send_request(OP_FORK, 16'd0);
	endtask

	// Shortest slice: every tick rotates; extreme sleep lengths.
	task automatic test_slice_limit_one();
		write_slice_limit(8'd1);
		repeat (3) send_request(OP_TICK, 16'd0);
		send_request(OP_SLEEP, 16'hFFFF);
		send_request(OP_SLEEP, 16'h0001);
		send_request(OP_EXIT, 16'h8000);
		send_request(OP_TICK, 16'h7FFF);
	endtask

	// Random bursts with gaps, the odd full drain between them.
	task automatic test_random_traffic(input int unsigned items, input int unsigned tick_weight);
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		sent = 0;
		while (sent < items) begin
			burst = $urandom_range(1, 12);
			for (int unsigned b = 0; b < burst && sent < items; b++) begin
				send_request(pick_operation(tick_weight), pick_sleep_ticks());
				sent++;
			end
			if ($urandom_range(0, 39) == 0) begin
				drain_results();
			end else begin
				gap = $urandom_range(0, 8);
				if (gap != 0)
					pause_sender(gap);
			end
		end
	endtask

	// Several limits, extremes included; limit 0 lets slices wrap past 255.
	task automatic test_slice_limit_sweep();
		write_slice_limit(8'd10);
		test_random_traffic(250, 40);
		write_slice_limit(8'd255);
		test_random_traffic(250, 80);
		write_slice_limit(8'd0);
		test_random_traffic(250, 85);
		write_slice_limit(8'd1);
		test_random_traffic(250, 40);
		write_slice_limit(8'($urandom_range(2, 20)));
		test_random_traffic(250, 50);
		write_slice_limit(8'd3);
		test_random_traffic(250, 40);
	endtask

	initial begin
		reset_image();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_idle_fallback();
		test_zero_sleep();
		test_fork_table_full();
		test_slice_limit_one();
		test_slice_limit_sweep();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && owed_outcomes.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
